/* rtl/stp_pkg.sv */
// Shared types and constants for the session ticket parser.
// Used by stp_parser and session_ticket_parser_core; depends on nothing.
`timescale 1ns / 1ps

package stp_pkg;

    // Field limits and extension codes
    localparam logic [31:0] MAX_NONCE_BYTES  = 32'd32;
    localparam logic [31:0] MAX_TICKET_BYTES = 32'd2048;
    localparam logic [15:0] EARLY_DATA_TYPE  = 16'd42;
    localparam logic [31:0] EARLY_DATA_LEN   = 32'd4;

    // Width of the signed extension byte count
    localparam int unsigned REM_W = 19;

    // Parse phases
    typedef enum logic [3:0] {
        PH_LIFE   = 4'd0,
        PH_AGE    = 4'd1,
        PH_NLEN   = 4'd2,
        PH_NONCE  = 4'd3,
        PH_TLEN   = 4'd4,
        PH_TICKET = 4'd5,
        PH_ELEN   = 4'd6,
        PH_ETYPE  = 4'd7,
        PH_EDLEN  = 4'd8,
        PH_EDVAL  = 4'd9,
        PH_OLEN   = 4'd10,
        PH_SKIP   = 4'd11,
        PH_DONE   = 4'd12
    } t_phase;

    // Result item kinds
    typedef enum logic [1:0] {
        KIND_NONCE   = 2'd0,
        KIND_TICKET  = 2'd1,
        KIND_SUMMARY = 2'd2
    } t_kind;

    // Every result one input item causes: an optional byte and an optional summary
    typedef struct packed {
        logic        has_byte;
        t_kind       byte_kind;
        logic [7:0]  data;
        logic        has_sum;
        logic        status;
        logic [31:0] lifetime;
        logic [31:0] age_add;
        logic [31:0] early;
        logic [31:0] birth;
        logic [5:0]  nlen;
        logic [11:0] tlen;
    } t_item_res;

endpackage

/* rtl/session_ticket_parser_core.sv */
// Session ticket parser top level: parse state machine and two-entry result queue.
// Depends on stp_pkg and stp_parser.
// A result is offered the cycle after its item is accepted, if the queue is empty.
// Throughput: one item per cycle while the queue is not full; an item with a byte and a
// summary keeps its entry until both are taken; items behind it may find the queue full.
// Reset: i_rst_n, synchronous active low, rearms the parser and empties the result queue.
`timescale 1ns / 1ps

module session_ticket_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_no_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_birth_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic        o_status,
    output logic [31:0] o_lifetime_s,
    output logic [31:0] o_age_add,
    output logic [31:0] o_early_data_limit,
    output logic [31:0] o_birth_out,
    output logic [5:0]  o_nonce_length,
    output logic [11:0] o_ticket_length,
    output logic        o_end_of_message
);
    import stp_pkg::*;

    t_item_res   r_q [2];
    logic        r_wr_ptr, r_rd_ptr;
    logic [1:0]  r_count;
    logic        r_sub;

    logic        accept;
    logic        push;
    t_item_res   res;
    t_item_res   head;
    logic        byte_part;
    logic        out_hs;
    logic        pop;

    assign o_in_ready = (r_count != 2'd2);
    assign accept     = i_in_valid && o_in_ready;

    stp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_data_byte),
        .i_no_byte    (i_no_byte),
        .i_last_byte  (i_last_byte),
        .i_birth_time (i_birth_time),
        .o_push       (push),
        .o_res        (res)
    );

    // Head of the queue: byte part first, then the summary
    assign head      = r_q[r_rd_ptr];
    assign byte_part = head.has_byte && !r_sub;
    assign out_hs    = o_out_valid && i_out_ready;
    assign pop       = out_hs && (!byte_part || !head.has_sum);

    // Store the results of each item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= res;
        end
    end

    // Advance queue pointers and the sub-item marker
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
            r_sub    <= 1'b0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
                r_sub    <= 1'b0;
            end else if (out_hs) begin
                r_sub    <= 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Drive the result item from the head entry
    always_comb begin
        o_out_valid        = (r_count != 2'd0);
        o_out_kind         = KIND_SUMMARY;
        o_out_byte         = '0;
        o_status           = 1'b0;
        o_lifetime_s       = '0;
        o_age_add          = '0;
        o_early_data_limit = '0;
        o_birth_out        = '0;
        o_nonce_length     = '0;
        o_ticket_length    = '0;
        o_end_of_message   = 1'b0;
        if (byte_part) begin
            o_out_kind = head.byte_kind;
            o_out_byte = head.data;
        end else begin
            o_status           = head.status;
            o_lifetime_s       = head.lifetime;
            o_age_add          = head.age_add;
            o_early_data_limit = head.early;
            o_birth_out        = head.birth;
            o_nonce_length     = head.nlen;
            o_ticket_length    = head.tlen;
            o_end_of_message   = 1'b1;
        end
    end

endmodule

/* rtl/stp_parser.sv */
// Byte-wise parse state machine of the session ticket parser.
// Takes one accepted item per cycle and forms its results; depends on stp_pkg.
`timescale 1ns / 1ps

module stp_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_no_byte,
    input  logic                i_last_byte,
    input  logic [31:0]         i_birth_time,
    output logic                o_push,
    output stp_pkg::t_item_res  o_res
);
    import stp_pkg::*;

    t_phase                   r_phase, n_phase;
    logic [15:0]              r_count, n_count;
    logic [31:0]              r_accum, n_accum;
    logic [31:0]              r_life, n_life;
    logic [31:0]              r_age, n_age;
    logic [31:0]              r_early, n_early;
    logic [31:0]              r_birth, n_birth;
    logic [7:0]               r_nlen, n_nlen;
    logic [15:0]              r_tlen, n_tlen;
    logic signed [REM_W-1:0]  r_rem, n_rem;
    logic                     r_err, n_err;

    logic                     start;
    logic [31:0]              acc_cur;
    logic [31:0]              val;
    logic [16:0]              cnt_inc;
    logic [15:0]              fsize;
    logic signed [REM_W-1:0]  rem_new;
    logic                     ok;
    t_item_res                res;

    // Next state and results of the item on the inputs
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_accum = r_accum;
        n_life  = r_life;
        n_age   = r_age;
        n_early = r_early;
        n_birth = r_birth;
        n_nlen  = r_nlen;
        n_tlen  = r_tlen;
        n_rem   = r_rem;
        n_err   = r_err;
        res     = '0;
        ok      = 1'b0;
        rem_new = r_rem;

        // First item of a message: sample birth time, clear the summary values
        start   = (r_phase == PH_LIFE) && (r_count == 16'd0) && !r_err;
        acc_cur = start ? 32'd0 : r_accum;
        if (start) begin
            n_birth = i_birth_time;
            n_life  = '0;
            n_age   = '0;
            n_early = '0;
            n_nlen  = '0;
            n_tlen  = '0;
            n_rem   = '0;
            n_accum = '0;
        end

        val     = {acc_cur[23:0], i_data_byte};
        cnt_inc = {1'b0, r_count} + 17'd1;

        unique case (r_phase)
            PH_LIFE, PH_AGE, PH_EDVAL: fsize = 16'd4;
            PH_NLEN:                   fsize = 16'd1;
            default:                   fsize = 16'd2;
        endcase

        // Consume the byte
        if (!i_no_byte && !r_err && (r_phase != PH_DONE)) begin
            unique case (r_phase)
                PH_NONCE: begin
                    res.has_byte  = 1'b1;
                    res.byte_kind = KIND_NONCE;
                    res.data      = i_data_byte;
                    n_count       = cnt_inc[15:0];
                    if (cnt_inc >= {9'd0, r_nlen}) begin
                        n_phase = PH_TLEN;
                        n_count = '0;
                    end
                end
                PH_TICKET: begin
                    res.has_byte  = 1'b1;
                    res.byte_kind = KIND_TICKET;
                    res.data      = i_data_byte;
                    n_count       = cnt_inc[15:0];
                    if (cnt_inc >= {1'b0, r_tlen}) begin
                        n_phase = PH_ELEN;
                        n_count = '0;
                    end
                end
                PH_SKIP: begin
                    n_count = cnt_inc[15:0];
                    if ({15'd0, cnt_inc} >= acc_cur) begin
                        n_phase = (r_rem > 0) ? PH_ETYPE : PH_DONE;
                        n_count = '0;
                        n_accum = '0;
                    end
                end
                PH_LIFE, PH_AGE, PH_NLEN, PH_TLEN, PH_ELEN,
                PH_ETYPE, PH_EDLEN, PH_EDVAL, PH_OLEN: begin
                    // Shift the byte into the field, act when it is complete
                    n_accum = val;
                    n_count = cnt_inc[15:0];
                    if (cnt_inc[15:0] >= fsize) begin
                        n_accum = '0;
                        n_count = '0;
                        unique case (r_phase)
                            PH_LIFE: begin
                                n_life  = val;
                                n_phase = PH_AGE;
                            end
                            PH_AGE: begin
                                n_age   = val;
                                n_phase = PH_NLEN;
                            end
                            PH_NLEN: begin
                                n_nlen = val[7:0];
                                if (val > MAX_NONCE_BYTES) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = (val == 32'd0) ? PH_TLEN : PH_NONCE;
                                end
                            end
                            PH_TLEN: begin
                                n_tlen = val[15:0];
                                if (val > MAX_TICKET_BYTES) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_phase = (val == 32'd0) ? PH_ELEN : PH_TICKET;
                                end
                            end
                            PH_ELEN: begin
                                rem_new = signed'({3'b000, val[15:0]});
                                n_rem   = rem_new;
                                n_phase = (rem_new > 0) ? PH_ETYPE : PH_DONE;
                            end
                            PH_ETYPE: begin
                                n_rem   = r_rem - 19'sd2;
                                n_phase = (val[15:0] == EARLY_DATA_TYPE) ? PH_EDLEN
                                                                         : PH_OLEN;
                            end
                            PH_EDLEN: begin
                                if (val != EARLY_DATA_LEN) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_rem   = r_rem - 19'sd2;
                                    n_phase = PH_EDVAL;
                                end
                            end
                            PH_EDVAL: begin
                                n_early = val;
                                rem_new = r_rem - 19'sd4;
                                n_rem   = rem_new;
                                n_phase = (rem_new > 0) ? PH_ETYPE : PH_DONE;
                            end
                            PH_OLEN: begin
                                rem_new = r_rem - 19'sd2 - signed'({3'b000, val[15:0]});
                                n_rem   = rem_new;
                                if (val == 32'd0) begin
                                    n_phase = (rem_new > 0) ? PH_ETYPE : PH_DONE;
                                end else begin
                                    n_accum = {16'd0, val[15:0]};
                                    n_phase = PH_SKIP;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                default: begin
                    // Codes past the done phase mean nothing: drop the message
                    n_err = 1'b1;
                end
            endcase
        end

        // Message end: form the summary and rearm for the next message
        if (i_no_byte || i_last_byte) begin
            ok = !n_err && ((n_phase == PH_DONE) ||
                            ((n_phase == PH_SKIP) && (n_rem <= 0)));
            res.has_sum = 1'b1;
            res.status  = !ok;
            if (ok) begin
                res.lifetime = n_life;
                res.age_add  = n_age;
                res.early    = n_early;
                res.birth    = n_birth;
                res.nlen     = n_nlen[5:0];
                res.tlen     = n_tlen[11:0];
            end
            n_phase = PH_LIFE;
            n_count = '0;
            n_accum = '0;
            n_err   = 1'b0;
        end
    end

    // Parse control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LIFE;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_err   <= n_err;
        end
    end

    // Field values, cleared on the first item of each message
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_accum <= n_accum;
            r_life  <= n_life;
            r_age   <= n_age;
            r_early <= n_early;
            r_birth <= n_birth;
            r_nlen  <= n_nlen;
            r_tlen  <= n_tlen;
            r_rem   <= n_rem;
        end
    end

    assign o_res  = res;
    assign o_push = i_accept && (res.has_byte || res.has_sum);

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for session_ticket_parser_core: byte-wise ticket messages in,
// nonce/ticket bytes and end-of-message summaries out, checked against a local predictor.
// Depends on stp_pkg and the RTL of the parser; needs no other files.
`timescale 1ns / 1ps

module tb_top;

    import stp_pkg::*;

    localparam int unsigned RESET_CYCLES   = 11;
    localparam int unsigned RANDOM_ITEMS   = 500;
    localparam int unsigned IDLE_PCT       = 37;
    localparam int unsigned CALM_FROM      = 170;
    localparam int unsigned CALM_TO        = 290;
    localparam int unsigned STALL_AT       = 380;
    localparam int unsigned STALL_CYCLES   = 200;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned WATCHDOG_LIMIT = 2000;

    // One result item as seen on the output ports
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        status;
        logic [31:0] lifetime;
        logic [31:0] age_add;
        logic [31:0] early;
        logic [31:0] birth;
        logic [5:0]  nlen;
        logic [11:0] tlen;
        logic        eom;
    } t_ticket_res;

    // Message shapes for the random part
    typedef enum {
        MSG_GOOD, MSG_CUT, MSG_NONCE_LONG, MSG_TICKET_LONG, MSG_EARLY_BAD,
        MSG_SKIP_END, MSG_NOB_END, MSG_EMPTY, MSG_NOISE
    } t_msg_style;

    // Ticket parse predictor and store of the results still owed by the block
    class t_ticket_scoreboard;
        t_phase      ph;
        int unsigned fcnt;
        logic [31:0] faccum;
        logic [31:0] life;
        logic [31:0] age;
        logic [31:0] early;
        logic [31:0] birth;
        logic [7:0]  nlen_r;
        logic [15:0] tlen_r;
        int          ext_rem;
        logic [15:0] etype;
        bit          err;

        t_ticket_res pending_results[$];
        int unsigned n_fail;
        int unsigned n_nonce;
        int unsigned n_ticket;
        int unsigned n_good;
        int unsigned n_bad;

        function new();
            ph      = PH_LIFE;
            fcnt    = 0;
            faccum  = '0;
            life    = '0;
            age     = '0;
            early   = '0;
            birth   = '0;
            nlen_r  = '0;
            tlen_r  = '0;
            ext_rem = 0;
            etype   = '0;
            err     = 1'b0;
            n_fail  = 0;
            n_nonce = 0;
            n_ticket = 0;
            n_good  = 0;
            n_bad   = 0;
        endfunction

        function void push_byte(t_kind k, logic [7:0] b);
            t_ticket_res r;
            r      = '0;
            r.kind = k;
            r.data = b;
            pending_results.push_back(r);
        endfunction

        function void push_summary(bit ok);
            t_ticket_res r;
            r      = '0;
            r.kind = KIND_SUMMARY;
            r.eom  = 1'b1;
            if (ok) begin
                r.lifetime = life;
                r.age_add  = age;
                r.early    = early;
                r.birth    = birth;
                r.nlen     = nlen_r[5:0];
                r.tlen     = tlen_r[11:0];
            end else begin
                r.status = 1'b1;
            end
            pending_results.push_back(r);
        endfunction

        // Close one extension: walk on while the block still counts bytes
        function void after_ext();
            ph     = (ext_rem > 0) ? PH_ETYPE : PH_DONE;
            fcnt   = 0;
            faccum = '0;
        endfunction

        function void parse_byte(logic [7:0] b);
            logic [31:0] val;
            int unsigned fsize;
            if (err || ph == PH_DONE)
                return;
            if (ph == PH_NONCE) begin
                push_byte(KIND_NONCE, b);
                fcnt++;
                if (fcnt >= nlen_r) begin
                    ph   = PH_TLEN;
                    fcnt = 0;
                end
            end else if (ph == PH_TICKET) begin
                push_byte(KIND_TICKET, b);
                fcnt++;
                if (fcnt >= tlen_r) begin
                    ph   = PH_ELEN;
                    fcnt = 0;
                end
            end else if (ph == PH_SKIP) begin
                fcnt++;
                if (fcnt >= faccum)
                    after_ext();
            end else begin
                // Gather a big-endian integer field
                faccum = {faccum[23:0], b};
                fcnt++;
                if (ph == PH_LIFE || ph == PH_AGE || ph == PH_EDVAL)
                    fsize = 4;
                else if (ph == PH_NLEN)
                    fsize = 1;
                else
                    fsize = 2;
                if (fcnt >= fsize) begin
                    val    = faccum;
                    faccum = '0;
                    fcnt   = 0;
                    case (ph)
                        PH_LIFE: begin
                            life = val;
                            ph   = PH_AGE;
                        end
                        PH_AGE: begin
                            age = val;
                            ph  = PH_NLEN;
                        end
                        PH_NLEN: begin
                            nlen_r = val[7:0];
                            if (val > MAX_NONCE_BYTES)
                                err = 1'b1;
                            else
                                ph = (val == 0) ? PH_TLEN : PH_NONCE;
                        end
                        PH_TLEN: begin
                            tlen_r = val[15:0];
                            if (val > MAX_TICKET_BYTES)
                                err = 1'b1;
                            else
                                ph = (val == 0) ? PH_ELEN : PH_TICKET;
                        end
                        PH_ELEN: begin
                            ext_rem = int'(val[15:0]);
                            after_ext();
                        end
                        PH_ETYPE: begin
                            etype   = val[15:0];
                            ext_rem = ext_rem - 2;
                            ph      = (etype == EARLY_DATA_TYPE) ? PH_EDLEN : PH_OLEN;
                        end
                        PH_EDLEN: begin
                            if (val != EARLY_DATA_LEN) begin
                                err = 1'b1;
                            end else begin
                                ext_rem = ext_rem - 2;
                                ph      = PH_EDVAL;
                            end
                        end
                        PH_EDVAL: begin
                            early   = val;
                            ext_rem = ext_rem - 4;
                            after_ext();
                        end
                        default: begin
                            // Other extension: skip its body
                            ext_rem = ext_rem - 2 - int'(val[15:0]);
                            if (val == 0) begin
                                after_ext();
                            end else begin
                                faccum = {16'd0, val[15:0]};
                                ph     = PH_SKIP;
                            end
                        end
                    endcase
                end
            end
        endfunction

        // Work out the results of one accepted input item
        function void note_item(logic [7:0] b, logic nob, logic last, logic [31:0] bt);
            bit ok;
            if (ph == PH_LIFE && fcnt == 0 && !err) begin
                birth   = bt;
                life    = '0;
                age     = '0;
                early   = '0;
                nlen_r  = '0;
                tlen_r  = '0;
                ext_rem = 0;
                etype   = '0;
                faccum  = '0;
            end
            if (!nob)
                parse_byte(b);
            if (nob || last) begin
                ok = !err && (ph == PH_DONE || (ph == PH_SKIP && ext_rem <= 0));
                push_summary(ok);
                ph     = PH_LIFE;
                fcnt   = 0;
                faccum = '0;
                err    = 1'b0;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                n_fail++;
            end
        endfunction

        // Compare one accepted result with the oldest one owed
        function void check_result(t_ticket_res got);
            t_ticket_res want;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: kind %0d byte %0h", got.kind, got.data);
                n_fail++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("out_kind", 32'(want.kind), 32'(got.kind));
            compare_field("out_byte", 32'(want.data), 32'(got.data));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("lifetime_s", want.lifetime, got.lifetime);
            compare_field("age_add", want.age_add, got.age_add);
            compare_field("early_data_limit", want.early, got.early);
            compare_field("birth_out", want.birth, got.birth);
            compare_field("nonce_length", 32'(want.nlen), 32'(got.nlen));
            compare_field("ticket_length", 32'(want.tlen), 32'(got.tlen));
            compare_field("end_of_message", 32'(want.eom), 32'(got.eom));
            if (want.kind == KIND_NONCE)
                n_nonce++;
            else if (want.kind == KIND_TICKET)
                n_ticket++;
            else if (want.status)
                n_bad++;
            else
                n_good++;
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_no_byte;
    logic        i_last_byte;
    logic [31:0] i_birth_time;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [1:0]  o_out_kind;
    logic [7:0]  o_out_byte;
    logic        o_status;
    logic [31:0] o_lifetime_s;
    logic [31:0] o_age_add;
    logic [31:0] o_early_data_limit;
    logic [31:0] o_birth_out;
    logic [5:0]  o_nonce_length;
    logic [11:0] o_ticket_length;
    logic        o_end_of_message;

    t_ticket_scoreboard sb = new();

    logic [7:0]  msg_q[$];
    bit          msg_nob_end;
    bit          armed = 1'b0;
    bit          calm = 1'b0;
    bit          stall_req = 1'b0;
    bit          pin_birth = 1'b0;
    logic [31:0] pin_birth_val;
    int unsigned items_sent = 0;
    int unsigned msgs_sent = 0;
    int unsigned quiet_cycles = 0;

    session_ticket_parser_core i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_data_byte        (i_data_byte),
        .i_no_byte          (i_no_byte),
        .i_last_byte        (i_last_byte),
        .i_birth_time       (i_birth_time),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_out_kind         (o_out_kind),
        .o_out_byte         (o_out_byte),
        .o_status           (o_status),
        .o_lifetime_s       (o_lifetime_s),
        .o_age_add          (o_age_add),
        .o_early_data_limit (o_early_data_limit),
        .o_birth_out        (o_birth_out),
        .o_nonce_length     (o_nonce_length),
        .o_ticket_length    (o_ticket_length),
        .o_end_of_message   (o_end_of_message)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Append big-endian integers and random bytes to the message
    function void put_be(logic [31:0] v, int nbytes);
        for (int i = nbytes - 1; i >= 0; i--)
            msg_q.push_back(v[8*i +: 8]);
    endfunction

    function void put_rand(int unsigned n);
        repeat (n)
            msg_q.push_back(8'($urandom));
    endfunction

    function void cut_message(int unsigned keep);
        while (msg_q.size() > keep)
            void'(msg_q.pop_back());
    endfunction

    function void build_message(t_msg_style style, int unsigned tlen);
        int unsigned nlen;
        int unsigned elen;
        int unsigned keep;
        int unsigned blk_pos;
        logic [15:0] blk;
        logic [15:0] etype;
        msg_q.delete();
        msg_nob_end = (style == MSG_EMPTY || style == MSG_NOB_END);
        if (style == MSG_EMPTY)
            return;
        if (style == MSG_NOISE) begin
            put_rand($urandom_range(1, 20));
            return;
        end
        nlen = ($urandom_range(4) == 0) ? 32 : $urandom_range(0, 8);
        if (style == MSG_NONCE_LONG)
            nlen = ($urandom_range(3) == 0) ? 255 : $urandom_range(33, 255);
        put_be($urandom(), 4);
        put_be($urandom(), 4);
        put_be(nlen, 1);
        if (style == MSG_NONCE_LONG) begin
            put_rand($urandom_range(0, 6));
            return;
        end
        put_rand(nlen);
        if (style == MSG_TICKET_LONG)
            tlen = ($urandom_range(3) == 0) ? 65535 : $urandom_range(2049, 65535);
        put_be(tlen, 2);
        if (style == MSG_TICKET_LONG) begin
            put_rand($urandom_range(0, 6));
            return;
        end
        put_rand(tlen);

        // Extension block: hold a place for its length and fill it in afterwards
        blk_pos = msg_q.size();
        put_be(0, 2);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(2) == 0) begin
                put_be(32'(EARLY_DATA_TYPE), 2);
                put_be(EARLY_DATA_LEN, 2);
                put_be($urandom(), 4);
            end else begin
                etype = 16'($urandom);
                if (etype == EARLY_DATA_TYPE)
                    etype = etype + 16'd1;
                elen = $urandom_range(0, 5);
                put_be(32'(etype), 2);
                put_be(elen, 2);
                put_rand(elen);
            end
        end
        if (style == MSG_EARLY_BAD) begin
            elen = $urandom_range(0, 65535);
            if (elen == EARLY_DATA_LEN)
                elen = 0;
            put_be(32'(EARLY_DATA_TYPE), 2);
            put_be(elen, 2);
            put_rand($urandom_range(0, 6));
        end
        blk = 16'(msg_q.size() - blk_pos - 2);
        if (style == MSG_SKIP_END) begin
            // Final extension body cut off by the message end
            etype = 16'($urandom);
            if (etype == EARLY_DATA_TYPE)
                etype = etype + 16'd1;
            elen = $urandom_range(1, 8);
            keep = $urandom_range(0, elen - 1);
            put_be(32'(etype), 2);
            put_be(elen, 2);
            put_rand(keep);
            blk = blk + 16'(4 + elen);
            if ($urandom_range(1) == 0)
                blk = blk + 16'($urandom_range(1, 6));
        end else if ($urandom_range(5) == 0) begin
            blk = 16'($urandom_range(0, blk + 6));
        end
        msg_q[blk_pos]     = blk[15:8];
        msg_q[blk_pos + 1] = blk[7:0];

        if (style == MSG_GOOD && $urandom_range(4) == 0)
            put_rand($urandom_range(1, 4));
        if (style == MSG_CUT)
            cut_message($urandom_range(1, msg_q.size() - 1));
        if (style == MSG_NOB_END)
            cut_message($urandom_range(1, msg_q.size()));
    endfunction

    // Offer one item, hold it until accepted, then note it for prediction
    task automatic send_item(logic [7:0] b, logic nob, logic last);
        logic [31:0] bt;
        bt = pin_birth ? pin_birth_val : $urandom();
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_data_byte  <= b;
        i_no_byte    <= nob;
        i_last_byte  <= last;
        i_birth_time <= bt;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        sb.note_item(b, nob, last, bt);
        items_sent++;
        calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
        if (items_sent == STALL_AT)
            stall_req = 1'b1;
    endtask

    task automatic send_message();
        int unsigned n;
        n = msg_q.size();
        for (int unsigned i = 0; i < n; i++)
            send_item(msg_q[i], 1'b0, (i == n - 1) && !msg_nob_end);
        if (msg_nob_end)
            send_item(8'($urandom), 1'b1, 1'($urandom));
        msgs_sent++;
    endtask

    // Receiver: random back-pressure, one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        wait (armed);
        forever begin
            if (stall_req) begin
                stall_req = 1'b0;
                repeat (STALL_CYCLES) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
                @(posedge i_clk);
            end
        end
    end

    // Check every accepted result
    always @(posedge i_clk) begin
        t_ticket_res got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.kind     = o_out_kind;
            got.data     = o_out_byte;
            got.status   = o_status;
            got.lifetime = o_lifetime_s;
            got.age_add  = o_age_add;
            got.early    = o_early_data_limit;
            got.birth    = o_birth_out;
            got.nlen     = o_nonce_length;
            got.tlen     = o_ticket_length;
            got.eom      = o_end_of_message;
            sb.check_result(got);
        end
    end

    // Drop the run when neither channel moves for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int unsigned pick;
        t_msg_style  style;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_data_byte  <= '0;
        i_no_byte    <= 1'b0;
        i_last_byte  <= 1'b0;
        i_birth_time <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        armed = 1'b1;

        // Directed: empty message, no-byte inside a message, nonce length at its
        // maximum code, then the shortest valid ticket with extreme values
        build_message(MSG_EMPTY, 0);
        send_message();
        msg_q = '{8'hFF, 8'h00};
        msg_nob_end = 1'b1;
        send_message();
        msg_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        msg_nob_end = 1'b0;
        pin_birth = 1'b1;
        pin_birth_val = 32'h0000_0000;
        send_message();
        msg_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h00, 8'h00, 8'h00, 8'h00};
        pin_birth_val = 32'hFFFF_FFFF;
        send_message();
        pin_birth = 1'b0;

        // Random messages, mostly well formed
        while (items_sent < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 55)
                style = MSG_GOOD;
            else if (pick < 63)
                style = MSG_CUT;
            else if (pick < 68)
                style = MSG_NONCE_LONG;
            else if (pick < 73)
                style = MSG_TICKET_LONG;
            else if (pick < 79)
                style = MSG_EARLY_BAD;
            else if (pick < 87)
                style = MSG_SKIP_END;
            else if (pick < 93)
                style = MSG_NOB_END;
            else if (pick < 96)
                style = MSG_EMPTY;
            else
                style = MSG_NOISE;
            build_message(style, $urandom_range(0, 12));
            send_message();
        end

        // Ticket length at its limit, message cut short a few ticket bytes in
        msg_q.delete();
        put_be($urandom(), 4);
        put_be($urandom(), 4);
        put_be(0, 1);
        put_be(MAX_TICKET_BYTES, 2);
        put_rand(20);
        msg_nob_end = 1'b0;
        send_message();
        i_in_valid <= 1'b0;

        // Wait for every owed result, then let the pipeline settle
        while (sb.pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d messages in %0d input items; %0d nonce and %0d ticket bytes checked",
                 msgs_sent, items_sent, sb.n_nonce, sb.n_ticket);
        $display("Summaries checked: %0d valid, %0d bad; one long output stall applied",
                 sb.n_good, sb.n_bad);
        if (sb.pending_results.size() != 0)
            $error("%0d expected results never arrived", sb.pending_results.size());
        if (sb.n_fail == 0 && sb.pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/stp_pkg.sv
rtl/stp_parser.sv
rtl/session_ticket_parser_core.sv
dv/tb_top.sv
